// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and constants shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Default pool capacity in slots
  localparam int unsigned MAX_SLOTS_DEF = 256;

  // Field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned POOL_W   = 21;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned STRIDE_W = 17;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Divider iteration counts: pool size is 21 bits, address offset 32 bits
  localparam int unsigned DIV_CNT_W     = 6;
  localparam int unsigned DIV_FMT_STEPS = POOL_W;
  localparam int unsigned DIV_REL_STEPS = ADDR_W;

  // Link word in front of each payload
  localparam logic [ADDR_W-1:0] LINK_BYTES = 32'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 2'd2;

  typedef enum logic [1:0] {
    ACT_FORMAT  = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_DELETE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_DELETED  = 3'd4,
    ST_BAD_ADDR = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_DIV_END,
    S_ALLOC_RD,
    S_MUL,
    S_ADDR,
    S_RESP
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_start;
    logic    div_step;
    logic    pop;
    logic    idx_mem;
    logic    take_fresh;
    logic    mul;
    logic    addr;
    logic    commit_fmt;
    logic    commit_rel;
    logic    commit_del;
    logic    set_status;
    status_e status;
    logic    emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    action_e action;
    logic    live;
    logic    bad_size;
    logic    no_space;
    logic    stack_empty;
    logic    fresh_avail;
    logic    div_last;
    logic    rel_ok;
  } sts_t;

endpackage

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer for the pool allocator: decodes the action and steps the
// datapath through division, stack access, address build and response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  fbpa_pkg::sts_t      sts_i,
  output fbpa_pkg::cmd_t      cmd_o
);

  fbpa_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != fbpa_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      fbpa_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = fbpa_pkg::S_DISPATCH;
        end
      end
      fbpa_pkg::S_DISPATCH: begin
        priority if (sts_i.action == fbpa_pkg::ACT_FORMAT) begin
          priority if (sts_i.bad_size) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = fbpa_pkg::ST_BAD_SIZE;
            state_d          = fbpa_pkg::S_RESP;
          end else if (sts_i.no_space) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = fbpa_pkg::ST_NO_SPACE;
            state_d          = fbpa_pkg::S_RESP;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = fbpa_pkg::S_DIV;
          end
        end else if (!sts_i.live) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = fbpa_pkg::ST_DELETED;
          state_d          = fbpa_pkg::S_RESP;
        end else if (sts_i.action == fbpa_pkg::ACT_ALLOC) begin
          // Prefer the most recently released slot, then a fresh one
          priority if (!sts_i.stack_empty) begin
            cmd_o.pop = 1'b1;
            state_d   = fbpa_pkg::S_ALLOC_RD;
          end else if (sts_i.fresh_avail) begin
            cmd_o.take_fresh = 1'b1;
            state_d          = fbpa_pkg::S_MUL;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = fbpa_pkg::ST_EMPTY;
            state_d          = fbpa_pkg::S_RESP;
          end
        end else if (sts_i.action == fbpa_pkg::ACT_RELEASE) begin
          cmd_o.div_start = 1'b1;
          state_d         = fbpa_pkg::S_DIV;
        end else begin
          cmd_o.commit_del = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = fbpa_pkg::ST_OK;
          state_d          = fbpa_pkg::S_RESP;
        end
      end
      fbpa_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = fbpa_pkg::S_DIV_END;
        end
      end
      fbpa_pkg::S_DIV_END: begin
        cmd_o.set_status = 1'b1;
        state_d          = fbpa_pkg::S_RESP;
        priority if (sts_i.action == fbpa_pkg::ACT_FORMAT) begin
          cmd_o.commit_fmt = 1'b1;
          cmd_o.status     = fbpa_pkg::ST_OK;
        end else if (sts_i.rel_ok) begin
          cmd_o.commit_rel = 1'b1;
          cmd_o.status     = fbpa_pkg::ST_OK;
        end else begin
          cmd_o.status = fbpa_pkg::ST_BAD_ADDR;
        end
      end
      fbpa_pkg::S_ALLOC_RD: begin
        cmd_o.idx_mem = 1'b1;
        state_d       = fbpa_pkg::S_MUL;
      end
      fbpa_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = fbpa_pkg::S_ADDR;
      end
      fbpa_pkg::S_ADDR: begin
        cmd_o.addr       = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = fbpa_pkg::ST_OK;
        state_d          = fbpa_pkg::S_RESP;
      end
      fbpa_pkg::S_RESP: begin
        cmd_o.emit = 1'b1;
        state_d    = fbpa_pkg::S_IDLE;
      end
      default: begin
        state_d = fbpa_pkg::S_IDLE;
      end
    endcase
  end

  // Checks
  `ASSERT_PROP(a_start_takes, clk_i, rst_ni, (start_i && (state_q == fbpa_pkg::S_IDLE)) |=> busy_o)
  `ASSERT_PROP(a_emit_ends, clk_i, rst_ni, cmd_o.emit |=> (state_q == fbpa_pkg::S_IDLE))

endmodule

// ===== rtl/fbpa_dp.sv =====
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath of the pool allocator: configuration registers, pool state,
// free-slot stack memory, shared restoring divider, address multiplier and
// response registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpa_dp #(
  parameter int unsigned MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]         cfg_wdata_i,
  // request payload
  input  logic [1:0]                          action_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]         release_address_i,
  // control
  input  fbpa_pkg::cmd_t                      cmd_i,
  output fbpa_pkg::sts_t                      sts_o,
  // response
  output logic                                done_o,
  output logic [2:0]                          status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]         slot_address_o,
  output logic [fbpa_pkg::IDX_OUT_W-1:0]      slot_index_o,
  output logic [fbpa_pkg::CNT_OUT_W-1:0]      slots_free_o,
  output logic [fbpa_pkg::CNT_OUT_W-1:0]      slots_total_o
);

  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned SW = fbpa_pkg::STRIDE_W;
  localparam int unsigned AW = fbpa_pkg::ADDR_W;
  localparam int unsigned PW = IW + SW;

  // Configuration registers
  logic [AW-1:0]                     pool_base_q;
  logic [fbpa_pkg::POOL_W-1:0]       pool_bytes_q;
  logic [fbpa_pkg::SIZE_W-1:0]       slot_bytes_q;

  // Pool state
  logic [CW-1:0] stack_q, fresh_q, total_q;
  logic [SW-1:0] stride_q;
  logic          live_q;

  // Request and work registers
  fbpa_pkg::action_e act_q;
  logic [AW-1:0]     addr_q;
  logic [IW-1:0]     idx_q;
  logic [PW-1:0]     prod_q;
  logic [AW-1:0]     res_addr_q;
  logic [IW-1:0]     res_idx_q;
  fbpa_pkg::status_e status_q;

  // Divider registers
  logic [AW-1:0]                  quo_q;
  logic [SW-1:0]                  rem_q;
  logic [SW-1:0]                  dvsr_q;
  logic [fbpa_pkg::DIV_CNT_W-1:0] div_cnt_q;

  // Stack memory
  logic [IW-1:0] mem [MAX_SLOTS];
  logic [IW-1:0] rd_data_q;

  // Response registers
  logic              done_q;
  fbpa_pkg::status_e out_status_q;
  logic [AW-1:0]     out_addr_q;
  logic [fbpa_pkg::IDX_OUT_W-1:0] out_idx_q;
  logic [fbpa_pkg::CNT_OUT_W-1:0] out_free_q, out_total_q;

  // Derived values
  logic [SW-1:0]   size_rnd;
  logic [SW-1:0]   stride_cfg;
  logic            bad_size;
  logic            no_space;
  logic [CW-1:0]   free_cnt;
  logic [CW-1:0]   stack_dec;
  logic [AW-1:0]   offset;
  logic [SW+1:0]   trial;
  logic [SW:0]     shifted;
  logic [AW-1:0]   quo_sat;
  logic [AW-1:0]   free_wide, total_wide, idx_wide;

  // Slot geometry from the configuration
  assign size_rnd   = ({1'b0, slot_bytes_q} + SW'(3)) & ~SW'(3);
  assign bad_size   = size_rnd[SW-1];
  assign stride_cfg = size_rnd + SW'(fbpa_pkg::LINK_BYTES);
  assign no_space   = fbpa_pkg::POOL_W'(stride_cfg) > pool_bytes_q;

  assign free_cnt  = stack_q + total_q - fresh_q;
  assign stack_dec = stack_q - CW'(1);
  assign offset    = addr_q - fbpa_pkg::LINK_BYTES - pool_base_q;

  // One restoring division step
  assign shifted = {rem_q, quo_q[AW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvsr_q};

  assign quo_sat = (quo_q > AW'(MAX_SLOTS)) ? AW'(MAX_SLOTS) : quo_q;

  // Status to controller
  always_comb begin
    sts_o.action      = act_q;
    sts_o.live        = live_q;
    sts_o.bad_size    = bad_size;
    sts_o.no_space    = no_space;
    sts_o.stack_empty = (stack_q == '0);
    sts_o.fresh_avail = (fresh_q < total_q);
    sts_o.div_last    = (div_cnt_q == fbpa_pkg::DIV_CNT_W'(1));
    sts_o.rel_ok      = (rem_q == '0) && (quo_q < AW'(total_q)) && (free_cnt < total_q);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_bytes_q <= '0;
      slot_bytes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbpa_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
        fbpa_pkg::REG_POOL_BYTES: pool_bytes_q <= cfg_wdata_i[fbpa_pkg::POOL_W-1:0];
        fbpa_pkg::REG_SLOT_BYTES: slot_bytes_q <= cfg_wdata_i[fbpa_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pool state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q  <= '0;
      fresh_q  <= '0;
      total_q  <= '0;
      stride_q <= '0;
      live_q   <= 1'b0;
    end else begin
      if (cmd_i.commit_fmt) begin
        stride_q <= dvsr_q;
        total_q  <= CW'(quo_sat);
        stack_q  <= '0;
        fresh_q  <= '0;
        live_q   <= 1'b1;
      end
      if (cmd_i.commit_del) begin
        live_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        stack_q <= stack_dec;
      end
      if (cmd_i.commit_rel) begin
        stack_q <= stack_q + CW'(1);
      end
      if (cmd_i.take_fresh) begin
        fresh_q <= fresh_q + CW'(1);
      end
    end
  end

  // Divider: load and iterate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= (act_q == fbpa_pkg::ACT_FORMAT) ?
                   fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_FMT_STEPS) :
                   fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_REL_STEPS);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - fbpa_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (act_q == fbpa_pkg::ACT_FORMAT) begin
        // Pool size sits at the top so its quotient lands in the low bits
        quo_q  <= {pool_bytes_q, (AW - fbpa_pkg::POOL_W)'(0)};
        dvsr_q <= stride_cfg;
      end else begin
        quo_q  <= offset;
        dvsr_q <= stride_q;
      end
    end else if (cmd_i.div_step) begin
      if (!trial[SW+1]) begin
        rem_q <= trial[SW-1:0];
        quo_q <= {quo_q[AW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[SW-1:0];
        quo_q <= {quo_q[AW-2:0], 1'b0};
      end
    end
  end

  // Request capture, index, address build and status
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= fbpa_pkg::action_e'(action_i);
      addr_q     <= release_address_i;
      res_addr_q <= '0;
      res_idx_q  <= '0;
    end
    if (cmd_i.take_fresh) begin
      idx_q <= fresh_q[IW-1:0];
    end
    if (cmd_i.idx_mem) begin
      idx_q <= rd_data_q;
    end
    if (cmd_i.mul) begin
      prod_q <= {{SW{1'b0}}, idx_q} * {{IW{1'b0}}, stride_q};
    end
    if (cmd_i.addr) begin
      res_addr_q <= pool_base_q + AW'(prod_q) + fbpa_pkg::LINK_BYTES;
      res_idx_q  <= idx_q;
    end
    if (cmd_i.commit_rel) begin
      res_addr_q <= addr_q;
      res_idx_q  <= quo_q[IW-1:0];
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // Free-slot stack: push on release, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_rel) begin
      mem[stack_q[IW-1:0]] <= quo_q[IW-1:0];
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem[stack_dec[IW-1:0]];
    end
  end

  // Response: mask counts and index to the port widths
  assign free_wide  = live_q ? AW'(free_cnt) : '0;
  assign total_wide = live_q ? AW'(total_q) : '0;
  assign idx_wide   = AW'(res_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_addr_q   <= res_addr_q;
      out_idx_q    <= idx_wide[fbpa_pkg::IDX_OUT_W-1:0];
      out_free_q   <= free_wide[fbpa_pkg::CNT_OUT_W-1:0];
      out_total_q  <= total_wide[fbpa_pkg::CNT_OUT_W-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = out_status_q;
  assign slot_address_o = out_addr_q;
  assign slot_index_o   = out_idx_q;
  assign slots_free_o   = out_free_q;
  assign slots_total_o  = out_total_q;

  // Checks
  `ASSERT_PROP(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)
  `ASSERT_PROP(a_fresh_bound, clk_i, rst_ni, live_q |-> (fresh_q <= total_q))
  `ASSERT_NEVER(a_free_bound, clk_i, rst_ni, live_q && (free_cnt > total_q))
  `ASSERT_PROP(a_fail_no_addr, clk_i, rst_ni, (done_q && (out_status_q != fbpa_pkg::ST_OK)) |-> (out_addr_q == '0))

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a LIFO free list: format, allocate, release
// and delete, one request at a time.
// ----------------------------------------------------------------------------
// Each request goes from idle through dispatch to the response state:
// delete and checks that fail at dispatch go there directly, allocate passes
// the multiply and address states (from the free list after a stack read),
// and format and release run the shared one-bit-per-cycle divider (21 and 32 steps).
// busy stays high until the response is registered, so a new request can
// be taken in the cycle the done strobe is shown; the receiver cannot stall.
// Reset clears configuration, pool state (deleted) and the strobe; the slot
// stack memory has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]         cfg_wdata_i,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]         release_address_i,
  // response
  output logic                                done_o,
  output logic [2:0]                          status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]         slot_address_o,
  output logic [fbpa_pkg::IDX_OUT_W-1:0]      slot_index_o,
  output logic [fbpa_pkg::CNT_OUT_W-1:0]      slots_free_o,
  output logic [fbpa_pkg::CNT_OUT_W-1:0]      slots_total_o
);

  fbpa_pkg::cmd_t cmd;
  fbpa_pkg::sts_t sts;

  // Sequencer
  fbpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Datapath
  fbpa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (action_i),
    .release_address_i (release_address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_address_o    (slot_address_o),
    .slot_index_o      (slot_index_o),
    .slots_free_o      (slots_free_o),
    .slots_total_o     (slots_total_o)
  );

endmodule
